@@ sv/sara_pkg.sv @@
// Shared types and constants for the shelf atlas rectangle allocator.
// Request/result beats, controller-datapath command and status, group codes.
// No dependencies.
package sara_pkg;

    localparam int GROUP_COUNT = 5;
    localparam int GROUP_W     = 3;
    localparam int DIM_W       = 12;
    localparam int PAGE_W      = 4;
    localparam int POS_W       = 11;
    localparam int WIDE_W      = 14;

    // Group codes
    localparam logic [GROUP_W-1:0] GRP_UI     = 3'd0;
    localparam logic [GROUP_W-1:0] GRP_TILE   = 3'd1;
    localparam logic [GROUP_W-1:0] GRP_OBJECT = 3'd2;
    localparam logic [GROUP_W-1:0] GRP_CHAR   = 3'd3;
    localparam logic [GROUP_W-1:0] GRP_MIXED  = 3'd4;

    // Status codes
    localparam logic [1:0] ST_PLACED    = 2'd0;
    localparam logic [1:0] ST_ALREADY   = 2'd1;
    localparam logic [1:0] ST_NO_PAGE   = 2'd2;
    localparam logic [1:0] ST_TOO_LARGE = 2'd3;

    typedef struct packed {
        logic [DIM_W-1:0] sprite_width;
        logic [DIM_W-1:0] sprite_height;
        logic             is_interface;
        logic             already_placed;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [GROUP_W-1:0] group_id;
        logic [PAGE_W-1:0]  page_index;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic wrap;
        logic commit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_blocked;
    } sts_t;

    // Route a rectangle to its group by UI flag and exact size
    function automatic logic [GROUP_W-1:0] pick_group(
        input logic [DIM_W-1:0] w,
        input logic [DIM_W-1:0] h,
        input logic             ui
    );
        logic [GROUP_W-1:0] g;
        begin
            if (ui)
                g = GRP_UI;
            else if (w == 12'd32 && h == 12'd32)
                g = GRP_TILE;
            else if (w == 12'd32 && h == 12'd64)
                g = GRP_OBJECT;
            else if (w == 12'd64 && h == 12'd64)
                g = GRP_CHAR;
            else
                g = GRP_MIXED;
            return g;
        end
    endfunction

endpackage

@@ sv/sara_ctrl.sv @@
// Controller for the shelf atlas allocator: capture, wrap and commit sequencing.
// Depends on sara_pkg for the command and status structs.
module sara_ctrl
    import sara_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_WRAP   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Decode commands and next state
    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.wrap    = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_WRAP;
                end
            end
            S_WRAP:
            begin
                cmd.wrap   = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (!sts.out_blocked)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != S_IDLE);

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // An accepted beat always moves on to the wrap step
    a_accept_to_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == S_WRAP))
        else $error("accepted request did not enter wrap step");

    // Wrap is always followed by commit
    a_wrap_to_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRAP) |=> (state_reg == S_COMMIT))
        else $error("wrap step not followed by commit");

    // Never overwrite a result that is still waiting
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !sts.out_blocked)
        else $error("commit while result register is blocked");

    // At most one command per cycle
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.wrap, cmd.commit}))
        else $error("more than one command issued");

endmodule

@@ sv/sara_datapath.sv @@
// Datapath for the shelf atlas allocator: per-group shelf state, fit checks,
// result register. Depends on sara_pkg; driven by sara_ctrl commands.
module sara_datapath
    import sara_pkg::*;
#(
    parameter int ATLAS_WIDTH     = 2048,
    parameter int ATLAS_HEIGHT    = 2048,
    parameter int PAGES_PER_GROUP = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    output sts_t sts,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam logic [WIDE_W-1:0] AW_LIM   = WIDE_W'(ATLAS_WIDTH);
    localparam logic [WIDE_W-1:0] AH_LIM   = WIDE_W'(ATLAS_HEIGHT);
    localparam logic [PAGE_W:0]   PAGE_LIM = (PAGE_W+1)'(PAGES_PER_GROUP);

    // Per-group shelf state
    logic [DIM_W-1:0]  shelf_x_reg      [GROUP_COUNT];
    logic [DIM_W-1:0]  shelf_y_reg      [GROUP_COUNT];
    logic [DIM_W-1:0]  shelf_height_reg [GROUP_COUNT];
    logic [PAGE_W-1:0] current_page_reg [GROUP_COUNT];

    // Captured request
    req_t               req_reg;
    logic [GROUP_W-1:0] grp_reg;

    // Wrap stage results
    logic [DIM_W-1:0]  x1_reg;
    logic [WIDE_W-1:0] y1_reg;
    logic [DIM_W-1:0]  rh1_reg;
    logic [PAGE_W-1:0] page_reg;
    logic              too_large_reg;

    // Result register
    logic rsp_valid_reg;
    logic rsp_valid_next;
    rsp_t rsp_reg;

    // Wrap stage logic
    logic [DIM_W-1:0]  cur_x;
    logic [DIM_W-1:0]  cur_y;
    logic [DIM_W-1:0]  cur_rh;
    logic [WIDE_W-1:0] w_wide;
    logic [WIDE_W-1:0] h_wide;
    logic              too_large;
    logic              row_full;
    logic [WIDE_W-1:0] y_wrapped;

    // Commit stage logic
    logic              need_page;
    logic              last_page;
    logic [1:0]        status;
    logic [PAGE_W-1:0] page_out;
    logic [DIM_W-1:0]  x2;
    logic [WIDE_W-1:0] y2;
    logic [DIM_W-1:0]  rh2;
    logic [DIM_W:0]    h_pad;
    logic [DIM_W-1:0]  x_new;
    logic [DIM_W-1:0]  rh_new;
    logic              placed;

    assign w_wide = WIDE_W'(req_reg.sprite_width);
    assign h_wide = WIDE_W'(req_reg.sprite_height);

    assign cur_x  = shelf_x_reg[grp_reg];
    assign cur_y  = shelf_y_reg[grp_reg];
    assign cur_rh = shelf_height_reg[grp_reg];

    // Size check and horizontal fit; start a new shelf on overflow
    always_comb
    begin
        too_large = (w_wide + WIDE_W'(2) > AW_LIM) || (h_wide + WIDE_W'(2) > AH_LIM);
        row_full  = (WIDE_W'(cur_x) + w_wide + WIDE_W'(2)) > AW_LIM;
        y_wrapped = WIDE_W'(cur_y) + WIDE_W'(cur_rh) + WIDE_W'(2);
    end

    // Vertical fit, page advance and new cursor
    always_comb
    begin
        need_page = (y1_reg + h_wide + WIDE_W'(2)) > AH_LIM;
        last_page = ({1'b0, page_reg} + (PAGE_W+1)'(1)) >= PAGE_LIM;
        if (req_reg.already_placed)
            status = ST_ALREADY;
        else if (too_large_reg)
            status = ST_TOO_LARGE;
        else if (need_page && last_page)
            status = ST_NO_PAGE;
        else
            status = ST_PLACED;
        placed   = (status == ST_PLACED);
        page_out = (placed && need_page) ? page_reg + PAGE_W'(1) : page_reg;
        x2       = need_page ? '0 : x1_reg;
        y2       = need_page ? '0 : y1_reg;
        rh2      = need_page ? '0 : rh1_reg;
        h_pad    = {1'b0, req_reg.sprite_height} + (DIM_W+1)'(1);
        x_new    = x2 + req_reg.sprite_width + DIM_W'(1);
        rh_new   = (h_pad > {1'b0, rh2}) ? h_pad[DIM_W-1:0] : rh2;
    end

    // Capture request and its group
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
            grp_reg <= pick_group(req.sprite_width, req.sprite_height, req.is_interface);
        end
    end

    // Hold wrap stage results
    always_ff @(posedge clk)
    begin
        if (cmd.wrap)
        begin
            x1_reg        <= row_full ? '0 : cur_x;
            y1_reg        <= row_full ? y_wrapped : WIDE_W'(cur_y);
            rh1_reg       <= row_full ? '0 : cur_rh;
            page_reg      <= current_page_reg[grp_reg];
            too_large_reg <= too_large;
        end
    end

    // Update group state on a successful placement
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < GROUP_COUNT; g++)
            begin
                shelf_x_reg[g]      <= '0;
                shelf_y_reg[g]      <= '0;
                shelf_height_reg[g] <= '0;
                current_page_reg[g] <= '0;
            end
        end
        else if (cmd.commit && placed)
        begin
            shelf_x_reg[grp_reg]      <= x_new;
            shelf_y_reg[grp_reg]      <= y2[DIM_W-1:0];
            shelf_height_reg[grp_reg] <= rh_new;
            current_page_reg[grp_reg] <= page_out;
        end
    end

    // Result beat payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_reg.status     <= status;
            rsp_reg.group_id   <= grp_reg;
            rsp_reg.page_index <= page_out;
            rsp_reg.pos_x      <= placed ? POS_W'(x2 + DIM_W'(1)) : '0;
            rsp_reg.pos_y      <= placed ? POS_W'(y2 + WIDE_W'(1)) : '0;
        end
    end

    // Result valid: set on commit, drop when the beat is taken
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.commit)
            rsp_valid_next = 1'b1;
        else if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    assign sts.out_blocked = rsp_valid_reg && rsp_stall;
    assign rsp_valid       = rsp_valid_reg;
    assign rsp             = rsp_reg;

endmodule

@@ sv/shelf_atlas_rect_allocator.sv @@
// Shelf atlas rectangle allocator: routes each rectangle to one of five groups.
// Each request beat passes through capture, wrap and commit steps to its result beat.
// The capture/wrap/commit sequencer takes no new request until the last one commits;
// a waiting result does not block the next request until its commit step.
// Reset (rst_n, async active low) clears all shelf cursors and page indexes.
module shelf_atlas_rect_allocator
    import sara_pkg::*;
#(
    parameter int ATLAS_WIDTH     = 2048,
    parameter int ATLAS_HEIGHT    = 2048,
    parameter int PAGES_PER_GROUP = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    cmd_t cmd;
    sts_t sts;

    // Sequencer
    sara_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Shelf state and fit logic
    sara_datapath #(
        .ATLAS_WIDTH     (ATLAS_WIDTH),
        .ATLAS_HEIGHT    (ATLAS_HEIGHT),
        .PAGES_PER_GROUP (PAGES_PER_GROUP)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

@@ sim/tb_shelf_atlas_rect_allocator.sv @@
// Self-checking testbench for shelf_atlas_rect_allocator: directed table, then random beats.
// Each result beat is scored against its table row or an in-bench shelf packer model, mostly under random stalls.
// Depends on sara_pkg (sv/sara_pkg.sv) and the allocator RTL.
module tb_shelf_atlas_rect_allocator;
    import sara_pkg::*;

    localparam int ATLAS_W          = 2048;
    localparam int ATLAS_H          = 2048;
    localparam int PAGE_COUNT       = 16;
    localparam int RANDOM_PER_PHASE = 550;
    localparam int HOLDOFF_AT       = 200;
    localparam int HOLDOFF_CYCLES   = 300;
    localparam int DRAIN_CYCLES     = 12;
    localparam int CYCLE_LIMIT      = 200000;

    typedef struct {
        req_t beat;
        int   reps;
        bit   typed;
        rsp_t want;
    } dir_row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Shelf cursors per group, mirrored in the bench
    logic [DIM_W-1:0]  cursor_x [GROUP_COUNT];
    logic [DIM_W-1:0]  cursor_y [GROUP_COUNT];
    logic [DIM_W-1:0]  row_h    [GROUP_COUNT];
    logic [PAGE_W-1:0] page_of  [GROUP_COUNT];

    rsp_t pending_rsp [$];
    rsp_t oldest;
    int   errors        = 0;
    int   results_seen  = 0;
    int   cycle_count   = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   holdoff_left  = 0;
    bit   holdoff_done  = 1'b0;

    // Directed beats: extremes, every group, each special case
    dir_row_t dir_table [14] = '{
        // zero-size rectangle lands at the first mixed slot
        '{'{12'd0, 12'd0, 1'b0, 1'b0}, 1, 1'b1, '{ST_PLACED, GRP_MIXED, 4'd0, 11'd1, 11'd1}},
        // already placed wins over oversize
        '{'{12'd2048, 12'd2048, 1'b1, 1'b1}, 1, 1'b1, '{ST_ALREADY, GRP_UI, 4'd0, 11'd0, 11'd0}},
        '{'{12'd2047, 12'd5, 1'b0, 1'b0}, 1, 1'b1, '{ST_TOO_LARGE, GRP_MIXED, 4'd0, 11'd0, 11'd0}},
        '{'{12'd5, 12'd2047, 1'b0, 1'b0}, 1, 1'b1, '{ST_TOO_LARGE, GRP_MIXED, 4'd0, 11'd0, 11'd0}},
        '{'{12'd4095, 12'd4095, 1'b1, 1'b0}, 1, 1'b1,
            '{ST_TOO_LARGE, GRP_UI, 4'd0, 11'd0, 11'd0}},
        // largest rectangle that fits a page
        '{'{12'd2046, 12'd2046, 1'b1, 1'b0}, 1, 1'b1, '{ST_PLACED, GRP_UI, 4'd0, 11'd1, 11'd1}},
        '{'{12'd32, 12'd32, 1'b0, 1'b0}, 1, 1'b1, '{ST_PLACED, GRP_TILE, 4'd0, 11'd1, 11'd1}},
        '{'{12'd32, 12'd64, 1'b0, 1'b0}, 1, 1'b1, '{ST_PLACED, GRP_OBJECT, 4'd0, 11'd1, 11'd1}},
        '{'{12'd64, 12'd64, 1'b0, 1'b0}, 1, 1'b1, '{ST_PLACED, GRP_CHAR, 4'd0, 11'd1, 11'd1}},
        // UI flag overrides exact size; forces a page advance
        '{'{12'd64, 12'd64, 1'b1, 1'b0}, 1, 1'b0, '0},
        // new shelf below the first one
        '{'{12'd2046, 12'd10, 1'b0, 1'b0}, 1, 1'b0, '0},
        // one page each until the UI group runs out of pages
        '{'{12'd2046, 12'd2046, 1'b1, 1'b0}, 15, 1'b0, '0},
        '{'{12'd32, 12'd32, 1'b0, 1'b1}, 1, 1'b1, '{ST_ALREADY, GRP_TILE, 4'd0, 11'd0, 11'd0}},
        '{'{12'd4095, 12'd0, 1'b0, 1'b1}, 1, 1'b1, '{ST_ALREADY, GRP_MIXED, 4'd0, 11'd0, 11'd0}}
    };

    shelf_atlas_rect_allocator #(
        .ATLAS_WIDTH     (ATLAS_W),
        .ATLAS_HEIGHT    (ATLAS_H),
        .PAGES_PER_GROUP (PAGE_COUNT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [GROUP_W-1:0] route_group(input req_t r);
        if (r.is_interface)
            return GRP_UI;
        if (r.sprite_width == 12'd32 && r.sprite_height == 12'd32)
            return GRP_TILE;
        if (r.sprite_width == 12'd32 && r.sprite_height == 12'd64)
            return GRP_OBJECT;
        if (r.sprite_width == 12'd64 && r.sprite_height == 12'd64)
            return GRP_CHAR;
        return GRP_MIXED;
    endfunction

    // Place one rectangle on its group's shelf and advance the cursor
    function automatic rsp_t place_rect(input req_t r);
        logic [GROUP_W-1:0] g;
        int unsigned w, h, x, y, rh, pg;
        rsp_t o;
        g = route_group(r);
        w = 32'(r.sprite_width);
        h = 32'(r.sprite_height);
        pg = 32'(page_of[g]);
        o.status = ST_PLACED;
        o.group_id = g;
        o.page_index = PAGE_W'(pg);
        o.pos_x = '0;
        o.pos_y = '0;
        if (r.already_placed)
            o.status = ST_ALREADY;
        else if (w + 2 > ATLAS_W || h + 2 > ATLAS_H)
            o.status = ST_TOO_LARGE;
        else
        begin
            x = 32'(cursor_x[g]);
            y = 32'(cursor_y[g]);
            rh = 32'(row_h[g]);
            // start a new shelf when the row is full
            if (x + w + 2 > ATLAS_W)
            begin
                x = 0;
                y = y + rh + 2;
                rh = 0;
            end
            // open a fresh page when the shelf runs off the bottom
            if (y + h + 2 > ATLAS_H)
            begin
                if (pg + 1 >= PAGE_COUNT)
                    o.status = ST_NO_PAGE;
                else
                begin
                    pg = pg + 1;
                    x = 0;
                    y = 0;
                    rh = 0;
                end
            end
            if (o.status == ST_PLACED)
            begin
                o.page_index = PAGE_W'(pg);
                o.pos_x = POS_W'(x + 1);
                o.pos_y = POS_W'(y + 1);
                x = x + w + 1;
                if (h + 1 > rh)
                    rh = h + 1;
                cursor_x[g] = DIM_W'(x);
                cursor_y[g] = DIM_W'(y);
                row_h[g] = DIM_W'(rh);
                page_of[g] = PAGE_W'(pg);
            end
        end
        return o;
    endfunction

    // Mostly group-routed rectangles, some flagged, oversized or UI
    function automatic req_t random_rect();
        req_t r;
        int unsigned sel;
        sel = $urandom_range(99);
        r.sprite_width = DIM_W'($urandom_range(120));
        r.sprite_height = DIM_W'($urandom_range(120));
        r.is_interface = 1'b0;
        r.already_placed = 1'b0;
        if ($urandom_range(9) == 0)
        begin
            r.sprite_width = DIM_W'($urandom_range(ATLAS_W - 2));
            r.sprite_height = DIM_W'($urandom_range(ATLAS_H - 2));
        end
        if (sel < 5)
        begin
            r.sprite_width = DIM_W'($urandom_range(4095));
            r.sprite_height = DIM_W'($urandom_range(4095));
            r.is_interface = 1'($urandom_range(1));
            r.already_placed = 1'b1;
        end
        else if (sel < 10)
        begin
            r.sprite_width = DIM_W'($urandom_range(4095, ATLAS_W - 1));
            r.sprite_height = DIM_W'($urandom_range(4095));
            r.is_interface = 1'($urandom_range(1));
            if ($urandom_range(1))
                {r.sprite_width, r.sprite_height} = {r.sprite_height, r.sprite_width};
        end
        else if (sel < 25)
            {r.sprite_width, r.sprite_height} = {12'd32, 12'd32};
        else if (sel < 40)
            {r.sprite_width, r.sprite_height} = {12'd32, 12'd64};
        else if (sel < 55)
            {r.sprite_width, r.sprite_height} = {12'd64, 12'd64};
        else if (sel < 70)
            r.is_interface = 1'b1;
        return r;
    endfunction

    // Offer one request beat, hold it until taken, then log its expected result
    task automatic send_beat(input req_t r, input bit typed, input rsp_t want);
        rsp_t guess;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        guess = place_rect(r);
        pending_rsp.push_back(typed ? want : guess);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Score result beats and drive the receiver stall
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            results_seen++;
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected result beat: expected none, got %h", $time, rsp);
                errors++;
            end
            else
            begin
                oldest = pending_rsp.pop_front();
                check_field("status", 32'(oldest.status), 32'(rsp.status));
                check_field("group_id", 32'(oldest.group_id), 32'(rsp.group_id));
                check_field("page_index", 32'(oldest.page_index), 32'(rsp.page_index));
                check_field("pos_x", 32'(oldest.pos_x), 32'(rsp.pos_x));
                check_field("pos_y", 32'(oldest.pos_y), 32'(rsp.pos_y));
            end
        end
        // hold off once for a long stretch so the block backs up
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            rsp_stall <= 1'b1;
        end
        else if (!holdoff_done && results_seen >= HOLDOFF_AT)
        begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        for (int g = 0; g < GROUP_COUNT; g++)
        begin
            cursor_x[g] = '0;
            cursor_y[g] = '0;
            row_h[g] = '0;
            page_of[g] = '0;
        end
        send_idle_pct = 18;
        recv_idle_pct = 69;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[i])
            repeat (dir_table[i].reps)
                send_beat(dir_table[i].beat, dir_table[i].typed, dir_table[i].want);

        // Sender-light, then receiver-light, then no idling
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 69 : 0;
            recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 18 : 0;
            repeat (RANDOM_PER_PHASE)
                send_beat(random_rect(), 1'b0, '0);
        end
        req_valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
